>>> rtl/rhss_pkg.sv
// Shared types and constants for the rolling-hash substring search unit.
package rhss_pkg;

  localparam int DIG_W   = 4;
  localparam int NDIG_W  = 4;
  localparam int XW      = 36;
  localparam int NDIG_MAX = XW / DIG_W;

  localparam logic [NDIG_W-1:0] ND_BYTE = NDIG_W'(2);
  localparam logic [NDIG_W-1:0] ND_HALF = NDIG_W'(4);
  localparam logic [NDIG_W-1:0] ND_PROD = NDIG_W'(8);
  localparam logic [NDIG_W-1:0] ND_FULL = NDIG_W'(9);

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_RADIX       = 2'd1;
  localparam logic [1:0] REG_HIGH_WEIGHT = 2'd2;
  localparam logic [1:0] REG_PATTERN_LEN = 2'd3;

  localparam logic [7:0] CHAR_BASE = 8'd48;

  typedef struct packed {
    logic              start;
    logic [NDIG_W-1:0] ndig;
    logic [XW-1:0]     x;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic win_shift;
    logic pat_shift;
  } cell_ctl_t;

endpackage

>>> rtl/rolling_hash_substring_search_unit.sv
// Top level: rolling-hash substring search with a chain of byte cells and a shared reducer.
// Pattern bytes are loaded first (tuser 0), then text bytes (tuser 1, tlast on the final one).
// A text word does more work once the window is full, as the outgoing byte is taken out of
// the hash; every hash step goes through one shared reducer that retires four bits of a value
// per cycle and is busy until done. The first word after reset or after any register write
// also waits while the radix, high weight and both stored hashes are reduced by the current
// modulus. A single result word is given per search, at the first match or at the last text
// word; the block keeps taking words while that result waits in its output register, until
// another result is due.
module rolling_hash_substring_search_unit #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // opcode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] found, [16:1] position, [17] overflow, rest zero
);
  import rhss_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = $clog2(MAX_TEXT + 1);

  localparam logic [1:0] PREP_RADIX = 2'd0;
  localparam logic [1:0] PREP_HW    = 2'd1;
  localparam logic [1:0] PREP_PH    = 2'd2;
  localparam logic [1:0] PREP_WH    = 2'd3;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PREP = 10'b0000000010,
    S_DISP = 10'b0000000100,
    S_CHAR = 10'b0000001000,
    S_OLD  = 10'b0000010000,
    S_SMUL = 10'b0000100000,
    S_SMOD = 10'b0001000000,
    S_MUL  = 10'b0010000000,
    S_MOD  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [15:0]      modulus, radix, high_weight;
  logic [4:0]       pattern_length;
  logic             stale;
  logic [1:0]       prep_idx;
  logic             issued;
  logic             op_q, last_q, ovf_q;
  logic [7:0]       byte_q;
  logic [15:0]      r_red, hw_red, ph_raw, ph_red, wh_raw, wh_red;
  logic [15:0]      c, oc, base;
  logic [31:0]      prod;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] fill;
  logic             search_done;
  logic             out_valid;
  logic             out_found, out_ovf;
  logic [15:0]      out_pos;

  logic [15:0]      m_eff;
  logic [LEN_W-1:0] len, len_m1;
  logic             cfg_wr;
  logic             mod_state;
  mod_req_t         mreq;
  mod_rsp_t         mres;
  cell_ctl_t        cctl;
  logic [7:0]       win [MAX_PATTERN];
  logic [7:0]       pat [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq, mask;
  logic [7:0]       old_byte;
  logic             win_full, text_ovf, chain_ok, hit, emit, slot_free;
  logic [31:0]      start_pos;
  logic [15:0]      res_fixed, t_sub;
  logic [16:0]      t_wide;

  function automatic logic [7:0] char_mag(input logic [7:0] b);
    char_mag = (b >= CHAR_BASE) ? (b - CHAR_BASE) : (CHAR_BASE - b);
  endfunction

  // --- configuration ---
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      REG_MODULUS:     prdata = 32'(modulus);
      REG_RADIX:       prdata = 32'(radix);
      REG_HIGH_WEIGHT: prdata = 32'(high_weight);
      REG_PATTERN_LEN: prdata = 32'(pattern_length);
      default:         prdata = '0;
    endcase
  end

  assign m_eff = (modulus < 16'd2) ? 16'd1 : modulus;

  always_comb begin
    if (pattern_length == 5'd0) begin
      len = LEN_W'(1);
    end else if (32'(pattern_length) > MAX_PATTERN) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(pattern_length);
    end
  end
  assign len_m1 = len - LEN_W'(1);

  // --- cell chain ---
  assign cctl.win_shift = (state == S_MOD) && mres.done && (op_q == OP_TEXT);
  assign cctl.pat_shift = (state == S_MOD) && mres.done && (op_q == OP_PATTERN);

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    if (i == 0) begin : g_head
      rhss_cell u_cell (
        .clk    (clk),
        .ctl    (cctl),
        .win_in (byte_q),
        .pat_in (byte_q),
        .win    (win[i]),
        .pat    (pat[i]),
        .eq     (eq[i])
      );
    end else begin : g_body
      rhss_cell u_cell (
        .clk    (clk),
        .ctl    (cctl),
        .win_in (win[i-1]),
        .pat_in (pat[i-1]),
        .win    (win[i]),
        .pat    (pat[i]),
        .eq     (eq[i])
      );
    end
    assign mask[i] = (i < int'(len));
  end

  assign old_byte = win[len_m1[IDX_W-1:0]];
  assign chain_ok = &(eq | ~mask);

  // --- shared reducer ---
  assign mod_state = (state == S_PREP) || (state == S_CHAR) || (state == S_OLD) ||
                     (state == S_SMOD) || (state == S_MOD);

  always_comb begin
    mreq.start = mod_state && !issued;
    mreq.ndig  = ND_FULL;
    mreq.x     = '0;
    case (state)
      S_PREP: begin
        mreq.ndig = ND_HALF;
        case (prep_idx)
          PREP_RADIX: mreq.x = XW'(radix);
          PREP_HW:    mreq.x = XW'(high_weight);
          PREP_PH:    mreq.x = XW'(ph_raw);
          PREP_WH:    mreq.x = XW'(wh_raw);
          default:    mreq.x = '0;
        endcase
      end
      S_CHAR: begin
        mreq.ndig = ND_BYTE;
        mreq.x    = XW'(char_mag(byte_q));
      end
      S_OLD: begin
        mreq.ndig = ND_BYTE;
        mreq.x    = XW'(char_mag(old_byte));
      end
      S_SMOD: begin
        mreq.ndig = ND_PROD;
        mreq.x    = XW'(prod);
      end
      S_MOD: begin
        mreq.ndig = ND_FULL;
        mreq.x    = XW'(prod) + XW'(c);
      end
      default: begin
        mreq.ndig = ND_FULL;
        mreq.x    = '0;
      end
    endcase
  end

  rhss_modred u_modred (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .m   (m_eff),
    .rsp (mres)
  );

  // negative character values wrap to m - r
  always_comb begin
    logic [7:0] b;
    b = (state == S_OLD) ? old_byte : byte_q;
    if ((b < CHAR_BASE) && (mres.rem != 16'd0)) begin
      res_fixed = m_eff - mres.rem;
    end else begin
      res_fixed = mres.rem;
    end
  end

  assign t_wide = (wh_red >= mres.rem) ? {1'b0, wh_red - mres.rem}
                                       : ({1'b0, wh_red} + {1'b0, m_eff} - {1'b0, mres.rem});
  assign t_sub  = t_wide[15:0];

  // --- result decision ---
  assign win_full  = 32'(count) >= 32'(len);
  assign text_ovf  = 32'(count) >= MAX_TEXT;
  assign start_pos = 32'(count) - 32'(len);
  assign hit       = !ovf_q && win_full && (fill == len) && (ph_red == wh_red) && chain_ok;
  assign emit      = ovf_q ? last_q : (hit || last_q);
  assign slot_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = stale ? S_PREP : S_DISP;
      S_PREP: if (mres.done && (prep_idx == PREP_WH)) state_next = S_DISP;
      S_DISP: begin
        if (op_q == OP_PATTERN) begin
          state_next = S_CHAR;
        end else if (search_done) begin
          state_next = S_IDLE;
        end else if (text_ovf) begin
          state_next = last_q ? S_FIN : S_IDLE;
        end else begin
          state_next = S_CHAR;
        end
      end
      S_CHAR: if (mres.done) state_next = ((op_q == OP_TEXT) && win_full) ? S_OLD : S_MUL;
      S_OLD:  if (mres.done) state_next = S_SMUL;
      S_SMUL: state_next = S_SMOD;
      S_SMOD: if (mres.done) state_next = S_MUL;
      S_MUL:  state_next = S_MOD;
      S_MOD:  if (mres.done) state_next = (op_q == OP_TEXT) ? S_FIN : S_IDLE;
      S_FIN:  if (!emit || slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      modulus        <= 16'd19;
      radix          <= 16'd10;
      high_weight    <= 16'd0;
      pattern_length <= 5'd1;
      stale          <= 1'b1;
      prep_idx       <= PREP_RADIX;
      issued         <= 1'b0;
      ph_raw         <= '0;
      ph_red         <= '0;
      wh_raw         <= '0;
      wh_red         <= '0;
      count          <= '0;
      fill           <= '0;
      search_done    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      if (mod_state) begin
        if (!issued) begin
          issued <= 1'b1;
        end else if (mres.done) begin
          issued <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q     <= s_tuser;
            byte_q   <= s_tdata;
            last_q   <= s_tlast;
            prep_idx <= PREP_RADIX;
          end
        end
        S_PREP: begin
          if (mres.done) begin
            case (prep_idx)
              PREP_RADIX: r_red  <= mres.rem;
              PREP_HW:    hw_red <= mres.rem;
              PREP_PH:    ph_red <= mres.rem;
              PREP_WH:    wh_red <= mres.rem;
              default:    r_red  <= mres.rem;
            endcase
            prep_idx <= prep_idx + 2'd1;
            if (prep_idx == PREP_WH) begin
              stale <= 1'b0;
            end
          end
        end
        S_DISP: begin
          ovf_q <= text_ovf;
          if (op_q == OP_PATTERN) begin
            if (fill >= len) begin
              fill   <= '0;
              ph_raw <= '0;
              ph_red <= '0;
            end
            count       <= '0;
            wh_raw      <= '0;
            wh_red      <= '0;
            search_done <= 1'b0;
          end else if ((search_done || text_ovf) && last_q && !(text_ovf && !search_done)) begin
            count       <= '0;
            wh_raw      <= '0;
            wh_red      <= '0;
            search_done <= 1'b0;
          end
        end
        S_CHAR: begin
          if (mres.done) begin
            c    <= res_fixed;
            base <= (op_q == OP_PATTERN) ? ph_red : wh_red;
          end
        end
        S_OLD: begin
          if (mres.done) begin
            oc <= res_fixed;
          end
        end
        S_SMUL: prod <= 32'(oc) * 32'(hw_red);
        S_SMOD: begin
          if (mres.done) begin
            base <= t_sub;
          end
        end
        S_MUL: prod <= 32'(r_red) * 32'(base);
        S_MOD: begin
          if (mres.done) begin
            if (op_q == OP_TEXT) begin
              wh_raw <= mres.rem;
              wh_red <= mres.rem;
              count  <= count + CNT_W'(1);
            end else begin
              ph_raw <= mres.rem;
              ph_red <= mres.rem;
              fill   <= fill + LEN_W'(1);
            end
          end
        end
        S_FIN: begin
          if (!emit || slot_free) begin
            if (emit) begin
              out_valid <= 1'b1;
              out_found <= hit;
              out_pos   <= hit ? start_pos[15:0] : 16'd0;
              out_ovf   <= ovf_q;
            end
            if (hit) begin
              search_done <= 1'b1;
            end
            if (last_q) begin
              count       <= '0;
              wh_raw      <= '0;
              wh_red      <= '0;
              search_done <= 1'b0;
            end
          end
        end
        default: ;
      endcase

      if (cfg_wr) begin
        stale <= 1'b1;
        case (paddr[3:2])
          REG_MODULUS:     modulus        <= pwdata[15:0];
          REG_RADIX:       radix          <= pwdata[15:0];
          REG_HIGH_WEIGHT: high_weight    <= pwdata[15:0];
          REG_PATTERN_LEN: pattern_length <= pwdata[4:0];
          default:         modulus        <= modulus;
        endcase
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_ovf, out_pos, out_found};

endmodule

>>> rtl/rhss_cell.sv
// One cell of the window/pattern chain: a text byte, a pattern byte and their compare.
module rhss_cell (
  input  logic              clk,
  input  rhss_pkg::cell_ctl_t ctl,
  input  logic [7:0]        win_in,
  input  logic [7:0]        pat_in,
  output logic [7:0]        win,
  output logic [7:0]        pat,
  output logic              eq
);
  import rhss_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.win_shift) begin
      win <= win_in;
    end
    if (ctl.pat_shift) begin
      pat <= pat_in;
    end
  end

  assign eq = (win == pat);

endmodule

>>> rtl/rhss_modred.sv
// Iterative reduction of a wide value by the modulus, four bits per cycle.
module rhss_modred (
  input  logic              clk,
  input  logic              rst,
  input  rhss_pkg::mod_req_t req,
  input  logic [15:0]       m,
  output rhss_pkg::mod_rsp_t rsp
);
  import rhss_pkg::*;

  logic [XW-1:0]     acc;
  logic [15:0]       rem;
  logic [NDIG_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [15:0]       rem_step;
  logic [5:0]        shamt;

  assign shamt = 6'({(NDIG_W'(NDIG_MAX) - req.ndig), 2'b00});

  always_comb begin
    logic [15:0] r;
    logic [16:0] t17;
    r   = rem;
    t17 = '0;
    for (int i = 0; i < DIG_W; i++) begin
      t17 = {r, acc[XW-1-i]};
      if (t17 >= {1'b0, m}) begin
        t17 = t17 - {1'b0, m};
      end
      r = t17[15:0];
    end
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.ndig;
        rem  <= '0;
        acc  <= req.x << shamt;
      end else if (busy) begin
        rem <= rem_step;
        acc <= acc << DIG_W;
        cnt <= cnt - NDIG_W'(1);
        if (cnt == NDIG_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the rolling-hash substring search unit.
`timescale 1ns / 1ps

module testbench;
  import rhss_pkg::*;

  localparam int PAT_DEPTH  = 16;
  localparam int PAT_IDX_W  = $clog2(PAT_DEPTH);
  localparam int TEXT_LIMIT = 65536;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic        ovf;
    logic [15:0] pos;
    logic        found;
  } search_result_t;

  typedef bit [7:0] byte_seq_t[$];

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] byte_value
  logic        s_tuser;   // opcode
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;   // [0] found, [16:1] position, [17] overflow, rest zero

  // predictor state
  bit [15:0]       cfg_mod = 16'd19;
  bit [15:0]       cfg_radix = 16'd10;
  bit [15:0]       cfg_hw = 16'd0;
  bit [4:0]        cfg_len = 5'd1;
  bit [7:0]        pat_mem[PAT_DEPTH];
  bit [7:0]        win_mem[PAT_DEPTH];
  longint unsigned pat_h = 0;
  longint unsigned win_h = 0;
  longint unsigned txt_cnt = 0;
  longint unsigned pat_fill = 0;
  bit              done_flag = 1'b0;

  search_result_t pending_results[$];
  int fail_count = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  rolling_hash_substring_search_unit #(
    .MAX_PATTERN(PAT_DEPTH),
    .MAX_TEXT(TEXT_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned char_res(input bit [7:0] b, input longint unsigned m);
    int v;
    int rr;
    v = int'(b) - int'(CHAR_BASE);
    rr = v % int'(m);
    if (rr < 0) rr += int'(m);
    return 64'(rr);
  endfunction

  function automatic void clear_search();
    txt_cnt = 0;
    win_h = 0;
    done_flag = 1'b0;
  endfunction

  // returns 1 when the word produces a result
  function automatic bit search_step(input logic op, input bit [7:0] b, input bit lst,
                                     output search_result_t res);
    longint unsigned m, len, r, c, wh, sub, t, k, start;
    bit same;
    res = '0;
    m = (cfg_mod < 16'd2) ? 64'd1 : 64'(cfg_mod);
    len = (cfg_len == 5'd0) ? 64'd1 : ((cfg_len > PAT_DEPTH) ? 64'(PAT_DEPTH) : 64'(cfg_len));
    r = 64'(cfg_radix) % m;
    if (op == OP_PATTERN) begin
      if (pat_fill >= len) begin
        pat_fill = 0;
        pat_h = 0;
      end
      pat_mem[PAT_IDX_W'(pat_fill)] = b;
      pat_h = (r * (pat_h % m) + char_res(b, m)) % m;
      pat_fill++;
      clear_search();
      return 1'b0;
    end
    if (done_flag) begin
      if (lst) clear_search();
      return 1'b0;
    end
    k = txt_cnt;
    if (k >= TEXT_LIMIT) begin
      txt_cnt = 64'(TEXT_LIMIT + 1);
      if (lst) begin
        clear_search();
        res.ovf = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    c = char_res(b, m);
    wh = win_h % m;
    if (k < len) begin
      wh = (r * wh + c) % m;
    end else begin
      sub = (char_res(win_mem[PAT_IDX_W'(k - len)], m) * (64'(cfg_hw) % m)) % m;
      t = (wh + m - sub) % m;
      wh = (r * t + c) % m;
    end
    win_h = wh;
    win_mem[PAT_IDX_W'(k)] = b;
    txt_cnt = k + 1;
    if (txt_cnt >= len && pat_fill == len && pat_h % m == wh) begin
      start = txt_cnt - len;
      same = 1'b1;
      for (longint unsigned j = 0; j < len; j++) begin
        if (win_mem[PAT_IDX_W'(start + j)] != pat_mem[PAT_IDX_W'(j)]) same = 1'b0;
      end
      if (same) begin
        done_flag = 1'b1;
        if (lst) clear_search();
        res.found = 1'b1;
        res.pos = start[15:0];
        return 1'b1;
      end
    end
    if (lst) begin
      clear_search();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit [15:0] power_mod(input bit [15:0] base, input int e, input bit [15:0] md);
    longint unsigned m, acc;
    m = (md < 16'd2) ? 64'd1 : 64'(md);
    acc = 1 % m;
    repeat (e) acc = (acc * base) % m;
    return acc[15:0];
  endfunction

  function automatic bit [7:0] rand_char();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return 8'(CHAR_BASE + 8'($urandom_range(2)));
  endfunction

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    search_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[16:1] !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, m_tdata[16:1]);
          fail_count++;
        end
        if (m_tdata[17] !== want.ovf) begin
          $error("overflow: expected %0d, got %0d", want.ovf, m_tdata[17]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_word(input logic op, input bit [7:0] b, input bit lst);
    search_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tuser = op;
    s_tlast = lst;
    do @(posedge clk); while (!s_tready);
    if (search_step(op, b, lst, res)) pending_results.push_back(res);
    words_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_pattern(input byte_seq_t seq);
    foreach (seq[i]) send_word(OP_PATTERN, seq[i], 1'($urandom_range(1)));
  endtask

  task automatic send_text(input byte_seq_t seq, input bit close);
    foreach (seq[i]) send_word(OP_TEXT, seq[i], close && (i == seq.size() - 1));
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input bit [15:0] value);
    bit [31:0] want;
    want = (idx == REG_PATTERN_LEN) ? 32'(value[4:0]) : 32'(value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODULUS:     cfg_mod = value;
      REG_RADIX:       cfg_radix = value;
      REG_HIGH_WEIGHT: cfg_hw = value;
      REG_PATTERN_LEN: cfg_len = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("register %0d readback: expected %0h, got %0h", idx, want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic program_regs(input bit [15:0] md, input bit [15:0] rad, input bit [15:0] hw,
                              input bit [4:0] len);
    settle();
    reg_write(REG_MODULUS, md);
    reg_write(REG_RADIX, rad);
    reg_write(REG_HIGH_WEIGHT, hw);
    reg_write(REG_PATTERN_LEN, 16'(len));
  endtask

  task automatic test_reset_values();
    send_pattern('{"5"});
    send_text('{"1", "2", "5"}, 1'b1);
  endtask

  task automatic test_field_extremes();
    program_regs(16'hFFFF, 16'hFFFF, power_mod(16'hFFFF, 2, 16'hFFFF), 5'd3);
    send_pattern('{8'h00, 8'hFF, 8'h30});
    send_text('{8'h00, 8'hFF, 8'h30}, 1'b1);
  endtask

  task automatic test_small_modulus();
    // modulus 0 with length 0, then modulus 1 with an oversized, never-filled pattern
    program_regs(16'd0, 16'd0, 16'hFFFF, 5'd0);
    send_pattern('{"q"});
    send_text('{"p", "q"}, 1'b1);
    program_regs(16'd1, 16'd7, 16'd0, 5'd31);
    send_pattern('{"a", "b"});
    send_text('{"a", "b", "c"}, 1'b1);
  endtask

  task automatic test_pattern_handling();
    program_regs(16'd101, 16'd256, power_mod(16'd256, 1, 16'd101), 5'd2);
    send_pattern('{"a", "b", "c", "d"});
    send_text('{"c", "d", "x"}, 1'b0);
    send_text('{"x"}, 1'b1);
    send_text('{"q"}, 1'b0);
    send_pattern('{"e"});
    send_text('{"e"}, 1'b1);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_words);
    bit [15:0]   mods[8];
    bit [15:0]   mod_v, rad_v, hw_v;
    bit [4:0]    len_v;
    byte_seq_t   pat, txt;
    bit          fresh;
    int unsigned stop_at, tlen, at, plen;
    settle();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    mods = '{16'd2, 16'd3, 16'd13, 16'd19, 16'd97, 16'd251, 16'd7919, 16'd65521};
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      fresh = ($urandom_range(1) == 0);
      if ($urandom_range(3) == 0) begin
        mod_v = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 2))
                                         : mods[3'($urandom_range(7))];
        rad_v = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(40));
        len_v = ($urandom_range(7) == 0) ? 5'd16 : 5'($urandom_range(5, 1));
        hw_v = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                        : power_mod(rad_v, int'(len_v) - 1, mod_v);
        program_regs(mod_v, rad_v, hw_v, len_v);
        fresh = 1'b1;
      end
      plen = (cfg_len == 5'd0) ? 1 : ((cfg_len > PAT_DEPTH) ? PAT_DEPTH : cfg_len);
      if (fresh) begin
        pat = {};
        repeat (plen) pat.push_back(rand_char());
        send_pattern(pat);
      end
      tlen = $urandom_range(3 * plen + 4, (plen > 1) ? plen - 1 : 1);
      txt = {};
      repeat (tlen) txt.push_back(rand_char());
      if (pat_fill == plen && tlen >= plen && $urandom_range(1) == 0) begin
        at = $urandom_range(tlen - plen);
        for (int j = 0; j < plen; j++) txt[at + j] = pat_mem[PAT_IDX_W'(j)];
      end
      if ($urandom_range(9) == 0) begin
        // abandoned search: text without an end, then a fresh or partial pattern
        send_text(txt, 1'b0);
        pat = {};
        repeat ($urandom_range(plen, 1)) pat.push_back(rand_char());
        send_pattern(pat);
      end else begin
        send_text(txt, 1'b1);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_PATTERN;
    s_tlast = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_values();
    test_field_extremes();
    test_small_modulus();
    test_pattern_handling();
    test_random_traffic(0, 0, 85);
    test_random_traffic(63, 0, 85);
    test_random_traffic(0, 63, 85);
    test_random_traffic(37, 37, 85);

    settle();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
